// ----- rtl/tgc_pkg.sv -----
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types and constants of the touchpad gesture classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] WINDOW_RESET   = 16'd400;
  localparam logic [23:0] SWIPE_TH_RESET = 24'd17920;
  localparam logic [23:0] PINCH_TH_RESET = 24'd65536;

  typedef enum logic [3:0] {
    CMD_PINCH_BEGIN  = 4'd0,
    CMD_PINCH_UPDATE = 4'd1,
    CMD_PINCH_END    = 4'd2,
    CMD_SWIPE_BEGIN  = 4'd3,
    CMD_SWIPE_UPDATE = 4'd4,
    CMD_SWIPE_END    = 4'd5,
    CMD_TAP_BEGIN    = 4'd6,
    CMD_TAP_UPDATE   = 4'd7,
    CMD_TAP_END      = 4'd8,
    CMD_TICK         = 4'd9
  } cmd_t;

  localparam logic [2:0] KIND_TAP       = 3'd0;
  localparam logic [2:0] KIND_PINCH     = 3'd1;
  localparam logic [2:0] KIND_SWIPE     = 3'd2;
  localparam logic [2:0] KIND_DTAP_DOWN = 3'd3;
  localparam logic [2:0] KIND_DRAG_MOVE = 3'd4;
  localparam logic [2:0] KIND_DRAG_STOP = 3'd5;

  localparam logic [2:0] DIR_NONE  = 3'd0;
  localparam logic [2:0] DIR_IN    = 3'd1;
  localparam logic [2:0] DIR_OUT   = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_RIGHT = 3'd4;
  localparam logic [2:0] DIR_UP    = 3'd5;
  localparam logic [2:0] DIR_DOWN  = 3'd6;

  localparam logic [1:0] CFG_WINDOW   = 2'd0;
  localparam logic [1:0] CFG_SWIPE_TH = 2'd1;
  localparam logic [1:0] CFG_PINCH_TH = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  dir;
    logic [3:0]  fingers;
    logic [23:0] mx;
    logic [23:0] my;
  } res_t;

  // one queue entry holds all reports of one item
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } qent_t;

endpackage

// ----- rtl/tgc_front.sv -----
// ----------------------------------------------------------------------------
// tgc_front
// Accepts items, updates gesture state and builds the reports of each item.
// ----------------------------------------------------------------------------
module tgc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [3:0]          in_command,
  input  logic [3:0]          in_finger_count,
  input  logic [23:0]         in_delta_x,
  input  logic [23:0]         in_delta_y,
  input  logic [23:0]         in_pinch_scale,
  input  logic                in_was_cancelled,
  input  logic                q_full,
  output logic                push,
  output tgc_pkg::qent_t      push_ent
);

  logic [15:0] window_r;
  logic [23:0] swipe_th_r;
  logic [23:0] pinch_th_r;

  logic [31:0] sum_x_r, sum_x_nxt;
  logic [31:0] sum_y_r, sum_y_nxt;
  logic [39:0] pinch_r, pinch_nxt;
  logic [3:0]  held_r, held_nxt;
  logic [31:0] tstart_r, tstart_nxt;
  logic        tvalid_r, tvalid_nxt;
  logic [15:0] cdown_r, cdown_nxt;
  logic        armed_r, armed_nxt;
  logic        drag_r, drag_nxt;
  logic [31:0] now_r, now_nxt;

  logic        accept;
  tgc_pkg::cmd_t cmd;

  logic [32:0] sx33, sy33;
  logic [31:0] sx_sat, sy_sat;
  logic [24:0] pdelta;
  logic [41:0] p42;
  logic [39:0] p_sat;
  logic [39:0] abs_p;
  logic [32:0] diff33, abs_d;
  logic [31:0] abs_x, abs_y;
  logic [2:0]  swipe_dir;
  logic [31:0] since_tap;

  logic            pre_v, m_v;
  tgc_pkg::res_t   pre_r, m_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign cmd       = tgc_pkg::cmd_t'(in_command);

  assign sx33   = {sum_x_r[31], sum_x_r} + {{9{in_delta_x[23]}}, in_delta_x};
  assign sy33   = {sum_y_r[31], sum_y_r} + {{9{in_delta_y[23]}}, in_delta_y};
  assign sx_sat = (sx33[32] != sx33[31]) ? {sx33[32], {31{!sx33[32]}}} : sx33[31:0];
  assign sy_sat = (sy33[32] != sy33[31]) ? {sy33[32], {31{!sy33[32]}}} : sy33[31:0];

  assign pdelta = 25'h010000 - {1'b0, in_pinch_scale};
  assign p42    = {{2{pinch_r[39]}}, pinch_r} + {{17{pdelta[24]}}, pdelta};
  assign p_sat  = ((p42[41] == p42[40]) && (p42[40] == p42[39])) ? p42[39:0]
                : {p42[41], {39{!p42[41]}}};

  assign abs_p  = pinch_r[39] ? (~pinch_r + 40'd1) : pinch_r;
  assign diff33 = {sum_x_r[31], sum_x_r} - {sum_y_r[31], sum_y_r};
  assign abs_d  = diff33[32] ? (~diff33 + 33'd1) : diff33;
  assign abs_x  = sum_x_r[31] ? (~sum_x_r + 32'd1) : sum_x_r;
  assign abs_y  = sum_y_r[31] ? (~sum_y_r + 32'd1) : sum_y_r;
  assign swipe_dir = (abs_x > abs_y) ? (sum_x_r[31] ? tgc_pkg::DIR_LEFT : tgc_pkg::DIR_RIGHT)
                                     : (sum_y_r[31] ? tgc_pkg::DIR_UP : tgc_pkg::DIR_DOWN);
  assign since_tap = now_r - tstart_r;

  always_comb begin
    sum_x_nxt  = sum_x_r;
    sum_y_nxt  = sum_y_r;
    pinch_nxt  = pinch_r;
    held_nxt   = held_r;
    tstart_nxt = tstart_r;
    tvalid_nxt = tvalid_r;
    cdown_nxt  = cdown_r;
    armed_nxt  = armed_r;
    drag_nxt   = drag_r;
    now_nxt    = now_r;
    pre_v      = 1'b0;
    pre_r      = '0;
    m_v        = 1'b0;
    m_r        = '0;

    if (drag_r && (cmd == tgc_pkg::CMD_PINCH_BEGIN || cmd == tgc_pkg::CMD_PINCH_UPDATE ||
                   cmd == tgc_pkg::CMD_PINCH_END || cmd == tgc_pkg::CMD_TAP_BEGIN)) begin
      held_nxt      = in_finger_count;
      pre_v         = 1'b1;
      pre_r.kind    = tgc_pkg::KIND_DRAG_STOP;
      pre_r.fingers = in_finger_count;
      drag_nxt      = 1'b0;
    end

    unique case (cmd)
      tgc_pkg::CMD_PINCH_BEGIN, tgc_pkg::CMD_SWIPE_BEGIN: begin
        sum_x_nxt  = '0;
        sum_y_nxt  = '0;
        pinch_nxt  = '0;
        held_nxt   = '0;
        tvalid_nxt = 1'b0;
        tstart_nxt = '0;
      end
      tgc_pkg::CMD_PINCH_UPDATE: begin
        pinch_nxt = p_sat;
      end
      tgc_pkg::CMD_SWIPE_UPDATE: begin
        sum_x_nxt = sx_sat;
        sum_y_nxt = sy_sat;
        if (drag_r) begin
          m_v       = 1'b1;
          m_r.kind  = tgc_pkg::KIND_DRAG_MOVE;
          m_r.fingers = in_finger_count;
          m_r.mx    = in_delta_x;
          m_r.my    = in_delta_y;
        end
      end
      tgc_pkg::CMD_PINCH_END: begin
        if (abs_p >= {16'd0, pinch_th_r}) begin
          m_v         = 1'b1;
          m_r.kind    = tgc_pkg::KIND_PINCH;
          m_r.dir     = pinch_r[39] ? tgc_pkg::DIR_OUT : tgc_pkg::DIR_IN;
          m_r.fingers = in_finger_count;
        end
        sum_x_nxt  = '0;
        sum_y_nxt  = '0;
        pinch_nxt  = '0;
        held_nxt   = '0;
        tvalid_nxt = 1'b0;
        tstart_nxt = '0;
        drag_nxt   = 1'b0;
      end
      tgc_pkg::CMD_SWIPE_END: begin
        if (drag_r) begin
          m_v         = 1'b1;
          m_r.kind    = tgc_pkg::KIND_DRAG_STOP;
          m_r.fingers = in_finger_count;
        end else if (abs_d >= {9'd0, swipe_th_r}) begin
          m_v         = 1'b1;
          m_r.kind    = tgc_pkg::KIND_SWIPE;
          m_r.dir     = swipe_dir;
          m_r.fingers = in_finger_count;
        end
        sum_x_nxt  = '0;
        sum_y_nxt  = '0;
        pinch_nxt  = '0;
        held_nxt   = '0;
        tvalid_nxt = 1'b0;
        tstart_nxt = '0;
        drag_nxt   = 1'b0;
      end
      tgc_pkg::CMD_TAP_BEGIN: begin
        if (tvalid_r && (since_tap <= {16'd0, window_r}) && (held_nxt == in_finger_count)) begin
          m_v         = 1'b1;
          m_r.kind    = tgc_pkg::KIND_DTAP_DOWN;
          m_r.fingers = held_nxt;
          armed_nxt   = 1'b0;
          cdown_nxt   = '0;
          sum_x_nxt   = '0;
          sum_y_nxt   = '0;
          pinch_nxt   = '0;
          held_nxt    = '0;
          tvalid_nxt  = 1'b0;
          tstart_nxt  = '0;
          drag_nxt    = 1'b1;
        end
      end
      tgc_pkg::CMD_TAP_END: begin
        if (in_was_cancelled || drag_r) begin
          sum_x_nxt  = '0;
          sum_y_nxt  = '0;
          pinch_nxt  = '0;
          held_nxt   = '0;
          tvalid_nxt = 1'b0;
          tstart_nxt = '0;
          drag_nxt   = 1'b0;
        end else begin
          held_nxt   = in_finger_count;
          tstart_nxt = now_r;
          tvalid_nxt = 1'b1;
          cdown_nxt  = window_r;
          armed_nxt  = 1'b1;
        end
      end
      tgc_pkg::CMD_TICK: begin
        now_nxt = now_r + 32'd1;
        if (armed_r) begin
          if (cdown_r <= 16'd1) begin
            armed_nxt   = 1'b0;
            cdown_nxt   = '0;
            m_v         = 1'b1;
            m_r.kind    = tgc_pkg::KIND_TAP;
            m_r.fingers = held_r;
          end else begin
            cdown_nxt = cdown_r - 16'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    push_ent = '0;
    if (pre_v) begin
      push_ent.r0  = pre_r;
      push_ent.r1  = m_r;
      push_ent.two = m_v;
    end else begin
      push_ent.r0  = m_r;
    end
  end

  assign push = accept && (pre_v || m_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= tgc_pkg::WINDOW_RESET;
      swipe_th_r <= tgc_pkg::SWIPE_TH_RESET;
      pinch_th_r <= tgc_pkg::PINCH_TH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tgc_pkg::CFG_WINDOW:   window_r   <= cfg_data[15:0];
        tgc_pkg::CFG_SWIPE_TH: swipe_th_r <= cfg_data;
        tgc_pkg::CFG_PINCH_TH: pinch_th_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      pinch_r  <= '0;
      held_r   <= '0;
      tstart_r <= '0;
      tvalid_r <= 1'b0;
      cdown_r  <= '0;
      armed_r  <= 1'b0;
      drag_r   <= 1'b0;
      now_r    <= '0;
    end else if (accept) begin
      sum_x_r  <= sum_x_nxt;
      sum_y_r  <= sum_y_nxt;
      pinch_r  <= pinch_nxt;
      held_r   <= held_nxt;
      tstart_r <= tstart_nxt;
      tvalid_r <= tvalid_nxt;
      cdown_r  <= cdown_nxt;
      armed_r  <= armed_nxt;
      drag_r   <= drag_nxt;
      now_r    <= now_nxt;
    end
  end

endmodule

// ----- rtl/tgc_queue.sv -----
// ----------------------------------------------------------------------------
// tgc_queue
// Short first-in first-out queue of report entries between front and back.
// ----------------------------------------------------------------------------
module tgc_queue #(
  parameter int DEPTH = tgc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tgc_pkg::qent_t push_ent,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tgc_pkg::qent_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tgc_pkg::qent_t ent_r [DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt;
  logic [PW-1:0]  rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_ent;
    end
  end

endmodule

// ----- rtl/tgc_back.sv -----
// ----------------------------------------------------------------------------
// tgc_back
// Takes queue entries apart into single reports and drives the result port.
// ----------------------------------------------------------------------------
module tgc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  tgc_pkg::qent_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output tgc_pkg::res_t  out_res,
  output logic           out_last
);

  logic          vld_r, vld_nxt;
  tgc_pkg::res_t res_r, res_nxt;
  logic          last_r, last_nxt;
  logic          pend_v_r, pend_v_nxt;
  tgc_pkg::res_t pend_r, pend_nxt;
  logic          load;

  assign load = !vld_r || out_ready;

  always_comb begin
    vld_nxt    = vld_r;
    res_nxt    = res_r;
    last_nxt   = last_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    pop        = 1'b0;
    if (load) begin
      priority if (pend_v_r) begin
        vld_nxt    = 1'b1;
        res_nxt    = pend_r;
        last_nxt   = 1'b1;
        pend_v_nxt = 1'b0;
      end else if (!q_empty) begin
        pop        = 1'b1;
        vld_nxt    = 1'b1;
        res_nxt    = head.r0;
        last_nxt   = !head.two;
        pend_v_nxt = head.two;
        pend_nxt   = head.r1;
      end else begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    last_r <= last_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;
  assign out_last  = last_r;

endmodule

// ----- rtl/touchpad_gesture_classifier.sv -----
// ----------------------------------------------------------------------------
// touchpad_gesture_classifier
// Classifies touchpad gesture events and millisecond ticks into reports.
// ----------------------------------------------------------------------------
// Input channel (in_*): one gesture event or one tick per item, valid/ready.
// Result channel (out_*): zero, one or two reports per item, out_last set on
//   the final report of each item.
// Configuration channel (cfg_*): cfg_ready is always high; index 0 window,
//   1 swipe threshold, 2 pinch threshold, other indexes ignored.
// Throughput: one item per cycle while the queue is not full; the front
//   updates all gesture state in the cycle of acceptance. An item with two
//   reports holds the output register for each report in turn.
// Path: a report passes a queue write, then an output register load, and
//   may wait longer while the receiver stalls.
// Reset: gesture state and time cleared, registers back to 400, 17920 and
//   65536, queue empty, no report pending.
// Receiver stall: reports wait in the output register and the queue; once
//   the queue holds QUEUE_DEPTH entries, in_ready drops until room frees.
// ----------------------------------------------------------------------------
module touchpad_gesture_classifier #(
  parameter int QUEUE_DEPTH = tgc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_command,
  input  logic [3:0]         in_finger_count,
  input  logic signed [23:0] in_delta_x,
  input  logic signed [23:0] in_delta_y,
  input  logic [23:0]        in_pinch_scale,
  input  logic               in_was_cancelled,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_report_kind,
  output logic [2:0]         out_direction,
  output logic [3:0]         out_fingers_out,
  output logic signed [23:0] out_move_x,
  output logic signed [23:0] out_move_y,
  output logic               out_last
);

  logic           q_full, q_empty, push, pop;
  tgc_pkg::qent_t push_ent, head;
  tgc_pkg::res_t  res;

  tgc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_finger_count  (in_finger_count),
    .in_delta_x       (in_delta_x),
    .in_delta_y       (in_delta_y),
    .in_pinch_scale   (in_pinch_scale),
    .in_was_cancelled (in_was_cancelled),
    .q_full           (q_full),
    .push             (push),
    .push_ent         (push_ent)
  );

  tgc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  tgc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .out_last  (out_last)
  );

  assign out_report_kind = res.kind;
  assign out_direction   = res.dir;
  assign out_fingers_out = res.fingers;
  assign out_move_x      = res.mx;
  assign out_move_y      = res.my;

endmodule
